FILE: hw/rtl/sld_pkg.sv
// Shared constants, codes and the result record of the frame detector.
// No dependencies; the files that use it refer to it by scoped names.
package sld_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam logic [15:0] MAX_LEN_RST    = 16'd1024;

  localparam logic [7:0]  HEAD_BYTE   = 8'hFF;
  localparam logic [7:0]  TAIL_BYTE   = 8'hFE;
  localparam int unsigned CHECK_LEN   = 4;
  localparam int unsigned FIXED_BYTES = 12;

  // Fixed frame offsets, head byte at zero.
  localparam int unsigned OFF_SEQ   = 5;
  localparam int unsigned OFF_CMD   = 6;
  localparam int unsigned OFF_LEN0  = 7;
  localparam int unsigned OFF_LEN1  = 8;
  localparam int unsigned OFF_LEN2  = 9;
  localparam int unsigned OFF_LEN3  = 10;

  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_GOOD     = 2'd1;
  localparam logic [1:0] ST_NO_TAIL  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] offset;
    logic [7:0]  seq_num;
    logic [7:0]  cmd_code;
    logic [15:0] payload_len;
    logic        last;
    logic [1:0]  status;
  } res_t;

  // Check bytes "ABCD" after the head.
  function automatic logic [7:0] check_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0: val = 8'h41;
      2'd1: val = 8'h42;
      2'd2: val = 8'h43;
      default: val = 8'h44;
    endcase
    return val;
  endfunction

endpackage

FILE: hw/rtl/sld_cfg.sv
// APB register block of the frame detector: holds the maximum frame length.
// Depends on sld_pkg.
module sld_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_len_o
);

  localparam logic IDX_MAX_LEN = 1'b0;

  logic [15:0] max_len_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == IDX_MAX_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= sld_pkg::MAX_LEN_RST;
    end else if (wr_en) begin
      max_len_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == IDX_MAX_LEN) begin
      prdata = {16'd0, max_len_q};
    end
  end

  assign max_len_o = max_len_q;

endmodule

FILE: hw/rtl/sld_in_reg.sv
// Input register of the frame detector: captures one received byte per transaction.
// Depends on nothing; the top level tells it when the held byte is consumed.
module sld_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       go_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       vld_q;
  logic [7:0] byte_q;

  assign ready_o = !vld_q || go_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = vld_q;
  assign byte_o  = byte_q;

endmodule

FILE: hw/rtl/sld_core.sv
// Frame parser of the frame detector: head hunt, check bytes, header fields,
// length limit and tail check. Depends on sld_pkg.
module sld_core #(
  parameter int unsigned COUNT_BITS = sld_pkg::COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [7:0]       byte_i,
  input  logic             go_i,
  input  logic [15:0]      max_len_i,
  output logic             res_valid_o,
  output sld_pkg::res_t    res_o
);

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_CHECK = 2'd1;
  localparam logic [1:0] PH_FRAME = 2'd2;

  localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_CHECK = COUNT_BITS'(sld_pkg::CHECK_LEN);
  localparam logic [COUNT_BITS-1:0] CNT_SEQ   = COUNT_BITS'(sld_pkg::OFF_SEQ);
  localparam logic [COUNT_BITS-1:0] CNT_CMD   = COUNT_BITS'(sld_pkg::OFF_CMD);
  localparam logic [COUNT_BITS-1:0] CNT_LEN0  = COUNT_BITS'(sld_pkg::OFF_LEN0);
  localparam logic [COUNT_BITS-1:0] CNT_LEN1  = COUNT_BITS'(sld_pkg::OFF_LEN1);
  localparam logic [COUNT_BITS-1:0] CNT_LEN2  = COUNT_BITS'(sld_pkg::OFF_LEN2);
  localparam logic [COUNT_BITS-1:0] CNT_LEN3  = COUNT_BITS'(sld_pkg::OFF_LEN3);
  localparam logic [COUNT_BITS-1:0] TAIL_ADD  = COUNT_BITS'(sld_pkg::OFF_LEN3 + 1);
  localparam logic [32:0] FIXED_W  = 33'(sld_pkg::FIXED_BYTES);
  localparam logic [32:0] CNT_SPAN = 33'd1 << COUNT_BITS;

  logic [1:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0]            seq_q, seq_d;
  logic [7:0]            cmd_q, cmd_d;
  logic [31:0]           len_q, len_d;
  logic [32:0]           total;
  logic                  too_long;
  logic                  tail_hit;

  assign cnt_inc  = cnt_q + CNT_ONE;
  assign total    = {1'b0, len_d} + FIXED_W;
  assign too_long = (total > {17'd0, max_len_i}) || (total > CNT_SPAN);
  assign tail_hit = (cnt_q > CNT_LEN3) && (cnt_q == (len_q[COUNT_BITS-1:0] + TAIL_ADD));

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    seq_d       = seq_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    res_valid_o = 1'b0;

    unique case (phase_q)
      PH_CHECK: begin
        if (byte_i == sld_pkg::check_byte(2'(cnt_q[1:0] - 2'd1))) begin
          cnt_d = cnt_inc;
          if (cnt_q == CNT_CHECK) begin
            phase_d = PH_FRAME;
            seq_d   = '0;
            cmd_d   = '0;
            len_d   = '0;
          end
        end else if (byte_i == sld_pkg::HEAD_BYTE) begin
          cnt_d = CNT_ONE;
        end else begin
          phase_d = PH_HUNT;
          cnt_d   = '0;
        end
      end
      PH_FRAME: begin
        res_valid_o = valid_i;
        if (cnt_q == CNT_SEQ) seq_d = byte_i;
        if (cnt_q == CNT_CMD) cmd_d = byte_i;
        if (cnt_q == CNT_LEN0) len_d[7:0]   = byte_i;
        if (cnt_q == CNT_LEN1) len_d[15:8]  = byte_i;
        if (cnt_q == CNT_LEN2) len_d[23:16] = byte_i;
        if (cnt_q == CNT_LEN3) len_d[31:24] = byte_i;
        if (((cnt_q == CNT_LEN3) && too_long) || tail_hit) begin
          phase_d = PH_HUNT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        // Head hunt; the unused phase code behaves the same.
        if (byte_i == sld_pkg::HEAD_BYTE) begin
          phase_d = PH_CHECK;
          cnt_d   = CNT_ONE;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    endcase
  end

  always_comb begin
    res_o.data_byte   = byte_i;
    res_o.offset      = 16'(cnt_q);
    res_o.seq_num     = seq_d;
    res_o.cmd_code    = cmd_d;
    res_o.payload_len = '0;
    res_o.last        = 1'b0;
    res_o.status      = sld_pkg::ST_BUSY;
    if (cnt_q >= CNT_LEN3) begin
      res_o.payload_len = (|len_d[31:16]) ? 16'hFFFF : len_d[15:0];
    end
    if (cnt_q == CNT_LEN3) begin
      if (too_long) begin
        res_o.last   = 1'b1;
        res_o.status = sld_pkg::ST_TOO_LONG;
      end
    end else if (tail_hit) begin
      res_o.last   = 1'b1;
      res_o.status = (byte_i == sld_pkg::TAIL_BYTE) ? sld_pkg::ST_GOOD : sld_pkg::ST_NO_TAIL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      seq_q   <= '0;
      cmd_q   <= '0;
      len_q   <= '0;
    end else if (go_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      seq_q   <= seq_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
    end
  end

endmodule

FILE: hw/rtl/sld_out_reg.sv
// Result register of the frame detector: holds one result until it is taken.
// Depends on sld_pkg for the result record.
module sld_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  sld_pkg::res_t res_i,
  output logic          valid_o,
  input  logic          ready_i,
  output sld_pkg::res_t res_o
);

  logic          vld_q;
  sld_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

FILE: hw/rtl/sync_length_frame_detector.sv
// Length-prefixed frame detector, top level.
// Results: an accepted byte waits in the input register; its result is loaded into the result register.
// Throughput: one byte per cycle, set by the single-pass parser between input and
// result registers; a full, unread result register stalls the input.
// Reset: asynchronous active low; returns to head hunt, max frame length 1024.
// Depends on sld_pkg, sld_cfg, sld_in_reg, sld_core and sld_out_reg.
module sync_length_frame_detector #(
  parameter int unsigned COUNT_BITS = sld_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic [15:0] offset_o,
  output logic [7:0]  seq_num_o,
  output logic [7:0]  cmd_code_o,
  output logic [15:0] payload_len_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          go;
  logic          res_valid;
  logic [15:0]   max_len;
  sld_pkg::res_t res;
  sld_pkg::res_t res_out;

  // Advance the held byte when it makes no result, or when the result
  // register is empty or being drained in this cycle.
  assign go = s1_valid && (!res_valid || !out_valid_o || out_ready_i);

  sld_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  sld_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .byte_i  (rx_byte_i),
    .go_i    (go),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  // Hunt, check, field capture and frame end decision, all in one pass.
  sld_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .byte_i      (s1_byte),
    .go_i        (go),
    .max_len_i   (max_len),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold a finished result until the downstream transaction completes.
  sld_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (go && res_valid),
    .res_i   (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign data_byte_o   = res_out.data_byte;
  assign offset_o      = res_out.offset;
  assign seq_num_o     = res_out.seq_num;
  assign cmd_code_o    = res_out.cmd_code;
  assign payload_len_o = res_out.payload_len;
  assign last_o        = res_out.last;
  assign status_o      = res_out.status;

endmodule

FILE: hw/rtl/sld_checker.sv
// Port-level checks of the frame detector, attached to the top level by bind.
// Depends on sld_pkg and sync_length_frame_detector.
module sld_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [7:0]  data_byte_o,
  input  logic [15:0] offset_o,
  input  logic [15:0] payload_len_o,
  input  logic        last_o,
  input  logic [1:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o) && $stable(offset_o))
    else $error("result changed while stalled");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (status_o != sld_pkg::ST_BUSY)))
    else $error("last and status disagree");

  a_too_long_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == sld_pkg::ST_TOO_LONG) |-> (offset_o == 16'd10))
    else $error("too long reported away from the last length byte");

  a_min_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (offset_o >= 16'd5))
    else $error("result before the header");

  a_len_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (offset_o < 16'd10) |-> (payload_len_o == 16'd0))
    else $error("payload length shown before it is complete");

endmodule

bind sync_length_frame_detector sld_checker u_sld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .data_byte_o   (data_byte_o),
  .offset_o      (offset_o),
  .payload_len_o (payload_len_o),
  .last_o        (last_o),
  .status_o      (status_o)
);

FILE: tb/sync_length_frame_detector_test.sv
// Self-checking testbench for sync_length_frame_detector: byte stream in, per-offset
// frame results out, compared against a cycle-free predictor kept in this file.
// Depends on sld_pkg and the RTL of sync_length_frame_detector.
module sync_length_frame_detector_test;

  // Register map: max_packet_len is register 0.
  localparam logic [2:0]    ADDR_MAX_LEN   = 3'd0;
  // "ABCD" as sent on the link, first check byte in the top lane.
  localparam logic [31:0]   SYNC_WORD      = 32'h4142_4344;
  localparam int unsigned   SETTLE_CYCLES  = 8;
  localparam int unsigned   CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned   RANDOM_RESULTS = 300;
  localparam int unsigned   POS_BITS       = sld_pkg::COUNT_BITS_DEF;
  localparam sld_pkg::res_t NO_RESULT      = '0;

  // Hunt state of the predictor; code 3 is never produced and falls back to head hunt.
  typedef enum logic [1:0] {
    HUNT_HEAD  = 2'd0,
    MATCH_SYNC = 2'd1,
    IN_FRAME   = 2'd2
  } sync_phase_e;

  // One row of the directed stream: the byte, and a hand-written result where typed is set.
  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    sld_pkg::res_t want;
  } hand_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  data_byte_o;
  logic [15:0] offset_o;
  logic [7:0]  seq_num_o;
  logic [7:0]  cmd_code_o;
  logic [15:0] payload_len_o;
  logic        last_o;
  logic [1:0]  status_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = ADDR_MAX_LEN;
  logic [31:0] pwdata      = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state, mirrors the block after reset.
  sync_phase_e          sync_phase    = HUNT_HEAD;
  logic [POS_BITS-1:0]  frame_pos     = '0;
  logic [7:0]           seq_seen      = 8'h00;
  logic [7:0]           cmd_seen      = 8'h00;
  logic [31:0]          len_seen      = 32'd0;
  logic [15:0]          max_frame_len = sld_pkg::MAX_LEN_RST;

  sld_pkg::res_t results_due [$];
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  int unsigned   rx_stall;
  int unsigned   cycle_count;
  int unsigned   mismatch_count;
  int unsigned   bytes_sent;
  int unsigned   results_predicted;
  int unsigned   results_checked;
  int unsigned   frames_good;
  int unsigned   frames_no_tail;
  int unsigned   frames_too_long;
  int unsigned   max_len_settings;

  sync_length_frame_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .offset_o      (offset_o),
    .seq_num_o     (seq_num_o),
    .cmd_code_o    (cmd_code_o),
    .payload_len_o (payload_len_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // Print one line per mismatch and count it; the run keeps going.
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch on %s: got 0x%0h, want 0x%0h (result #%0d, cycle %0d)",
             what, got, want, results_checked, cycle_count);
    mismatch_count++;
  endtask

  // Gap before the next transaction: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(input bit idle_on);
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic sld_pkg::res_t res_of(input logic [7:0] d, input logic [15:0] off,
                                           input logic [7:0] seq, input logic [7:0] cmd,
                                           input logic [15:0] plen, input logic lst,
                                           input logic [1:0] st);
    sld_pkg::res_t r;
    r.data_byte   = d;
    r.offset      = off;
    r.seq_num     = seq;
    r.cmd_code    = cmd;
    r.payload_len = plen;
    r.last        = lst;
    r.status      = st;
    return r;
  endfunction

  // Advance the predictor by one received byte. Returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, output sld_pkg::res_t r);
    logic [1:0]  sync_idx;
    logic [15:0] off;
    logic [32:0] frame_total;
    bit          emit;
    r    = NO_RESULT;
    emit = 1'b0;
    case (sync_phase)
      MATCH_SYNC: begin
        sync_idx = 2'(frame_pos - 1'b1);
        if (b == SYNC_WORD[8*(3 - int'(sync_idx)) +: 8]) begin
          frame_pos++;
          if (frame_pos == 1 + sld_pkg::CHECK_LEN) begin
            // Header fields restart from zero for the new frame.
            sync_phase = IN_FRAME;
            seq_seen   = 8'h00;
            cmd_seen   = 8'h00;
            len_seen   = 32'd0;
          end
        end else if (b == sld_pkg::HEAD_BYTE) begin
          // A head byte where a check byte was due opens a new frame right here.
          frame_pos = POS_BITS'(1);
        end else begin
          sync_phase = HUNT_HEAD;
          frame_pos  = '0;
        end
      end
      IN_FRAME: begin
        off = frame_pos;
        if (off == sld_pkg::OFF_SEQ) seq_seen = b;
        else if (off == sld_pkg::OFF_CMD) cmd_seen = b;
        else if (off >= sld_pkg::OFF_LEN0 && off <= sld_pkg::OFF_LEN3)
          len_seen = len_seen | (32'(b) << (8*(off - sld_pkg::OFF_LEN0)));
        r.data_byte   = b;
        r.offset      = off;
        r.seq_num     = seq_seen;
        r.cmd_code    = cmd_seen;
        r.payload_len = (off < sld_pkg::OFF_LEN3) ? 16'd0 :
                        (len_seen > 32'h0000_FFFF) ? 16'hFFFF : len_seen[15:0];
        if (off == sld_pkg::OFF_LEN3) begin
          // Length complete: reject against the maximum in force now and the counter range.
          frame_total = {1'b0, len_seen} + sld_pkg::FIXED_BYTES;
          if (frame_total > max_frame_len ||
              frame_total > (33'd1 << sld_pkg::COUNT_BITS_DEF)) begin
            r.last     = 1'b1;
            r.status   = sld_pkg::ST_TOO_LONG;
            sync_phase = HUNT_HEAD;
            frame_pos  = '0;
            frames_too_long++;
          end else begin
            frame_pos++;
          end
        end else if (off > sld_pkg::OFF_LEN3 &&
                     {17'd0, off} == {1'b0, len_seen} + 33'(sld_pkg::OFF_LEN3 + 1)) begin
          // Tail position: whatever byte sits here closes the frame.
          r.last     = 1'b1;
          r.status   = (b == sld_pkg::TAIL_BYTE) ? sld_pkg::ST_GOOD : sld_pkg::ST_NO_TAIL;
          sync_phase = HUNT_HEAD;
          frame_pos  = '0;
          if (b == sld_pkg::TAIL_BYTE) frames_good++;
          else frames_no_tail++;
        end else begin
          frame_pos++;
        end
        emit = 1'b1;
      end
      default: begin
        if (b == sld_pkg::HEAD_BYTE) begin
          sync_phase = MATCH_SYNC;
          frame_pos  = POS_BITS'(1);
        end
      end
    endcase
    return emit;
  endfunction

  // Send one byte as an input transaction, then queue what it should produce.
  // A typed row replaces the predicted result with the hand-written one.
  task automatic drive_byte(input logic [7:0] b, input bit typed,
                            input sld_pkg::res_t typed_res);
    int unsigned   gap;
    sld_pkg::res_t predicted;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    if (deframe_byte(b, predicted)) begin
      results_due.push_back(typed ? typed_res : predicted);
      results_predicted++;
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_byte(b, 1'b0, NO_RESULT);
  endtask

  // Whole frame with random seq, cmd and payload. Skip the payload when the
  // length gets the frame rejected, so the stream goes straight back to hunting.
  task automatic send_frame(input logic [31:0] plen, input logic [7:0] tail);
    send_byte(sld_pkg::HEAD_BYTE);
    for (int i = 0; i < sld_pkg::CHECK_LEN; i++) send_byte(SYNC_WORD[8*(3 - i) +: 8]);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    for (int i = 0; i < 4; i++) send_byte(plen[8*i +: 8]);
    if (sync_phase == IN_FRAME) begin
      repeat (plen) send_byte(8'($urandom));
      send_byte(tail);
    end
  endtask

  // Head plus part of the check word, then a random byte that most likely breaks it.
  task automatic send_broken_sync();
    int unsigned good_bytes;
    good_bytes = $urandom_range(0, 3);
    send_byte(sld_pkg::HEAD_BYTE);
    for (int i = 0; i < good_bytes; i++) send_byte(SYNC_WORD[8*(3 - i) +: 8]);
    send_byte(8'($urandom));
  endtask

  // Drop valid, wait for every pending result, then let any result-less byte drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic read_max_len(output logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= ADDR_MAX_LEN;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    v = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write max_packet_len while idle, then read it back through the same port.
  task automatic write_max_len(input logic [15:0] v);
    logic [31:0] rd;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_MAX_LEN;
    pwdata  <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    max_frame_len = v;
    max_len_settings++;
    read_max_len(rd);
    if (rd !== {16'd0, v}) report_mismatch("max_packet_len readback", rd, v);
  endtask

  // Result side: check each accepted result against the oldest expectation,
  // then hold ready low for a random stall before the next one.
  always @(posedge clk_i) begin : result_check
    sld_pkg::res_t got;
    sld_pkg::res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = res_of(data_byte_o, offset_o, seq_num_o, cmd_code_o, payload_len_o,
                     last_o, status_o);
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing pending, offset", got.offset, 0);
        end else begin
          want = results_due.pop_front();
          if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", got.data_byte, want.data_byte);
          if (got.offset !== want.offset)
            report_mismatch("offset", got.offset, want.offset);
          if (got.seq_num !== want.seq_num)
            report_mismatch("seq_num", got.seq_num, want.seq_num);
          if (got.cmd_code !== want.cmd_code)
            report_mismatch("cmd_code", got.cmd_code, want.cmd_code);
          if (got.payload_len !== want.payload_len)
            report_mismatch("payload_len", got.payload_len, want.payload_len);
          if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        end
        results_checked++;
        rx_stall = pick_gap(rx_idle_on);
      end
      if (rx_stall > 0) begin
        out_ready_i <= 1'b0;
        rx_stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    hand_row_t   hand_rows [27];
    logic [31:0] rd;
    logic [31:0] plen;
    logic [15:0] new_max;
    logic [7:0]  tail;
    int unsigned rand_start;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register comes out of reset at its default.
    read_max_len(rd);
    if (rd !== {16'd0, sld_pkg::MAX_LEN_RST})
      report_mismatch("max_packet_len after reset", rd, sld_pkg::MAX_LEN_RST);

    // Directed stream at the reset maximum:
    // - head then a wrong check byte: back to hunting
    // - head, 'A', then a head byte in place of 'B': restart from that head
    // - empty frame with seq 0xFF, cmd 0x00 and a proper tail
    // - frame with seq 0x00, cmd 0xFF and an all-ones length: rejected as too long
    hand_rows = '{
      {8'hFF, 1'b0, NO_RESULT},
      {8'h58, 1'b0, NO_RESULT},
      {8'hFF, 1'b0, NO_RESULT},
      {8'h41, 1'b0, NO_RESULT},
      {8'hFF, 1'b0, NO_RESULT},
      {8'h41, 1'b0, NO_RESULT},
      {8'h42, 1'b0, NO_RESULT},
      {8'h43, 1'b0, NO_RESULT},
      {8'h44, 1'b0, NO_RESULT},
      {8'hFF, 1'b1, res_of(8'hFF, 16'd5, 8'hFF, 8'h00, 16'd0, 1'b0, sld_pkg::ST_BUSY)},
      {8'h00, 1'b1, res_of(8'h00, 16'd6, 8'hFF, 8'h00, 16'd0, 1'b0, sld_pkg::ST_BUSY)},
      {8'h00, 1'b1, res_of(8'h00, 16'd7, 8'hFF, 8'h00, 16'd0, 1'b0, sld_pkg::ST_BUSY)},
      {8'h00, 1'b1, res_of(8'h00, 16'd8, 8'hFF, 8'h00, 16'd0, 1'b0, sld_pkg::ST_BUSY)},
      {8'h00, 1'b1, res_of(8'h00, 16'd9, 8'hFF, 8'h00, 16'd0, 1'b0, sld_pkg::ST_BUSY)},
      {8'h00, 1'b1, res_of(8'h00, 16'd10, 8'hFF, 8'h00, 16'd0, 1'b0, sld_pkg::ST_BUSY)},
      {8'hFE, 1'b1, res_of(8'hFE, 16'd11, 8'hFF, 8'h00, 16'd0, 1'b1, sld_pkg::ST_GOOD)},
      {8'hFF, 1'b0, NO_RESULT},
      {8'h41, 1'b0, NO_RESULT},
      {8'h42, 1'b0, NO_RESULT},
      {8'h43, 1'b0, NO_RESULT},
      {8'h44, 1'b0, NO_RESULT},
      {8'h00, 1'b0, NO_RESULT},
      {8'hFF, 1'b0, NO_RESULT},
      {8'hFF, 1'b0, NO_RESULT},
      {8'hFF, 1'b0, NO_RESULT},
      {8'hFF, 1'b0, NO_RESULT},
      {8'hFF, 1'b1, res_of(8'hFF, 16'd10, 8'h00, 8'hFF, 16'hFFFF, 1'b1,
                           sld_pkg::ST_TOO_LONG)}
    };
    foreach (hand_rows[i]) drive_byte(hand_rows[i].rx, hand_rows[i].typed, hand_rows[i].want);

    // Smallest legal maximum: only an empty payload fits; also a wrong tail.
    settle();
    write_max_len(16'd12);
    send_frame(32'd0, sld_pkg::TAIL_BYTE);
    send_frame(32'd0, 8'h00);
    send_frame(32'd1, sld_pkg::TAIL_BYTE);

    // Below the frame overhead every frame is rejected.
    settle();
    write_max_len(16'd11);
    send_frame(32'd0, sld_pkg::TAIL_BYTE);

    // Largest maximum, back to back: a frame that fits, then lengths just past the
    // maximum and past 16 bits, both rejected.
    settle();
    write_max_len(16'hFFFF);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_frame(32'd40, sld_pkg::TAIL_BYTE);
    send_frame(32'd65524, sld_pkg::TAIL_BYTE);
    send_frame(32'h0001_0000, sld_pkg::TAIL_BYTE);

    // Random phases: new maximum and idling mode per phase, mostly well-formed
    // frames with some noise, broken check words and bad tails mixed in.
    rand_start = results_predicted;
    while (results_predicted - rand_start < RANDOM_RESULTS) begin
      settle();
      case ($urandom_range(0, 3))
        0:       new_max = 16'd12;
        1:       new_max = 16'($urandom_range(13, 64));
        2:       new_max = 16'($urandom_range(65, 300));
        default: new_max = sld_pkg::MAX_LEN_RST;
      endcase
      write_max_len(new_max);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      repeat (4) begin
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        if ($urandom_range(0, 5) == 0) send_broken_sync();
        case ($urandom_range(0, 7))
          5:       plen = $urandom;
          6:       plen = (new_max <= 300) ? new_max - 16'd12 : $urandom_range(0, 24);
          7:       plen = (new_max <= 300) ? new_max - 16'd11 : $urandom_range(0, 24);
          default: plen = $urandom_range(0, 24);
        endcase
        tail = ($urandom_range(0, 7) == 0) ? 8'($urandom) : sld_pkg::TAIL_BYTE;
        send_frame(plen, tail);
      end
    end

    settle();
    $display("covered %0d bytes and %0d results in %0d cycles", bytes_sent, results_checked,
             cycle_count);
    $display("frames: %0d good, %0d tail missing, %0d too long; %0d maximum settings",
             frames_good, frames_no_tail, frames_too_long, max_len_settings);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
